[design/tps_pkg.sv]
// Shared codes and types for the triangle plane section block.
// Used by tps_dist, tps_merge and the top level; depends on nothing else.
package tps_pkg;

  localparam int NORMAL_BITS = 18;
  localparam int OFFSET_BITS = 32;
  localparam int FRAC_BITS   = 16;

  localparam logic [1:0] VERDICT_REMOVED = 2'd0;
  localparam logic [1:0] VERDICT_KEPT    = 2'd1;
  localparam logic [1:0] VERDICT_CUT     = 2'd2;
  localparam logic [1:0] VERDICT_BYPASS  = 2'd3;

  localparam logic [2:0] REG_ENABLE = 3'd0;
  localparam logic [2:0] REG_NX     = 3'd1;
  localparam logic [2:0] REG_NY     = 3'd2;
  localparam logic [2:0] REG_NZ     = 3'd3;
  localparam logic [2:0] REG_OFFSET = 3'd4;

  // Side of the plane on which one vertex lies.
  typedef struct packed {
    logic neg;
    logic zero;
  } dsign_t;

endpackage

[design/tps_dist.sv]
// One vertex lane: signed distance of a vertex to the plane in two stages.
// Depends on tps_pkg.
module tps_dist #(
  parameter int CB = 32,
  parameter int DW = 53
) (
  input  logic                                    clk_i,
  input  logic                                    en_i,
  input  logic signed [CB-1:0]                    x_i,
  input  logic signed [CB-1:0]                    y_i,
  input  logic signed [CB-1:0]                    z_i,
  input  logic signed [tps_pkg::NORMAL_BITS-1:0]  nx_i,
  input  logic signed [tps_pkg::NORMAL_BITS-1:0]  ny_i,
  input  logic signed [tps_pkg::NORMAL_BITS-1:0]  nz_i,
  input  logic signed [tps_pkg::OFFSET_BITS-1:0]  offset_i,
  output logic signed [DW-1:0]                    d_o,
  output tps_pkg::dsign_t                         sign_o
);

  localparam int PW = tps_pkg::NORMAL_BITS + CB;

  logic signed [PW-1:0] px_q, py_q, pz_q;
  logic signed [DW-1:0] d_q;
  logic signed [DW-1:0] off_w;

  assign off_w = DW'(offset_i) <<< tps_pkg::FRAC_BITS;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      px_q <= nx_i * x_i;
      py_q <= ny_i * y_i;
      pz_q <= nz_i * z_i;
      d_q  <= DW'(px_q) + DW'(py_q) + DW'(pz_q) - off_w;
    end
  end

  assign d_o         = d_q;
  assign sign_o.neg  = d_q[DW-1];
  assign sign_o.zero = (d_q == '0);

endmodule

[design/tps_edge.sv]
// One edge lane: the crossing point of an edge, one quotient bit per stage
// for each of the three coordinates. Uses no package.
module tps_edge #(
  parameter int CB = 32,
  parameter int DW = 53
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic signed [DW-1:0] da_i,
  input  logic signed [DW-1:0] db_i,
  input  logic signed [CB-1:0] va_i [3],
  input  logic signed [CB-1:0] vb_i [3],
  output logic signed [CB-1:0] pt_o [3]
);

  localparam int NSTEP = CB + 1;
  localparam int RW    = DW + 3;
  localparam int QW    = CB + 2;

  logic        [DW-1:0]    mda_q   [NSTEP+1];
  logic        [DW:0]      den_q   [NSTEP+1];
  logic        [CB:0]      mdel_q  [NSTEP+1][3];
  logic                    neg_q   [NSTEP+1][3];
  logic signed [CB-1:0]    va_q    [NSTEP+1][3];
  logic        [RW-1:0]    r_q     [NSTEP+1][3];
  logic        [QW-1:0]    q_q     [NSTEP+1][3];

  logic signed [DW:0] diff;
  assign diff = {da_i[DW-1], da_i} - {db_i[DW-1], db_i};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mda_q[0] <= da_i[DW-1] ? DW'(-da_i) : DW'(da_i);
      den_q[0] <= diff[DW] ? (DW+1)'(-diff) : (DW+1)'(diff);
      for (int k = 0; k < 3; k++) begin
        logic signed [CB:0] delta;
        delta = {vb_i[k][CB-1], vb_i[k]} - {va_i[k][CB-1], va_i[k]};
        mdel_q[0][k] <= delta[CB] ? (CB+1)'(-delta) : (CB+1)'(delta);
        neg_q[0][k]  <= delta[CB];
        va_q[0][k]   <= va_i[k];
        r_q[0][k]    <= '0;
        q_q[0][k]    <= '0;
      end
    end
  end

  // Running remainder stays below the divisor; adding one more multiple of
  // |da| can take it to under three divisors, hence two compares per step.
  for (genvar s = 0; s < NSTEP; s++) begin : g_step
    for (genvar k = 0; k < 3; k++) begin : g_coord
      logic [RW-1:0] r2, den1, den2, rn;
      logic [1:0]    t;
      always_comb begin
        den1 = RW'(den_q[s]);
        den2 = den1 << 1;
        r2   = (r_q[s][k] << 1) +
               (mdel_q[s][k][NSTEP-1-s] ? RW'(mda_q[s]) : '0);
        if (r2 >= den2) begin
          rn = r2 - den2;
          t  = 2'd2;
        end else if (r2 >= den1) begin
          rn = r2 - den1;
          t  = 2'd1;
        end else begin
          rn = r2;
          t  = 2'd0;
        end
      end
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          r_q[s+1][k]    <= rn;
          q_q[s+1][k]    <= (q_q[s][k] << 1) + QW'(t);
          mdel_q[s+1][k] <= mdel_q[s][k];
          neg_q[s+1][k]  <= neg_q[s][k];
          va_q[s+1][k]   <= va_q[s][k];
        end
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        mda_q[s+1] <= mda_q[s];
        den_q[s+1] <= den_q[s];
      end
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_pt
    assign pt_o[k] = neg_q[NSTEP][k] ? va_q[NSTEP][k] - $signed(q_q[NSTEP][k][CB-1:0])
                                     : va_q[NSTEP][k] + $signed(q_q[NSTEP][k][CB-1:0]);
  end

endmodule

[design/tps_merge.sv]
// Merging stage: classifies the triangle, picks the segment points from the
// vertex and edge lanes, keeps the running counts. Depends on tps_pkg.
module tps_merge #(
  parameter int CB = 32,
  parameter int NB = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  valid_i,
  input  logic                  bypass_i,
  input  tps_pkg::dsign_t       sign_i [3],
  input  logic signed [CB-1:0]  v_i    [3][3],
  input  logic signed [CB-1:0]  pt_i   [3][3],
  output logic                  valid_o,
  output logic [1:0]            verdict_o,
  output logic signed [CB-1:0]  p_o    [2][3],
  output logic [NB-1:0]         removed_o,
  output logic [NB-1:0]         kept_o,
  output logic [NB-1:0]         cut_o
);

  logic                 valid_q;
  logic [1:0]           verdict_q;
  logic signed [CB-1:0] p_q [2][3];
  logic [NB-1:0]        removed_q, kept_q, cut_q;

  logic [1:0]           verdict;
  logic signed [CB-1:0] pts [2][3];

  always_comb begin
    logic [1:0] np;
    logic       all_pos, all_neg, all_zero, dup, opp;
    int         b;
    np       = 2'd0;
    dup      = 1'b0;
    all_pos  = 1'b1;
    all_neg  = 1'b1;
    all_zero = 1'b1;
    for (int c = 0; c < 3; c++) begin
      all_pos  = all_pos & !sign_i[c].neg & !sign_i[c].zero;
      all_neg  = all_neg & sign_i[c].neg;
      all_zero = all_zero & sign_i[c].zero;
    end
    for (int j = 0; j < 2; j++)
      for (int i = 0; i < 3; i++) pts[j][i] = '0;
    for (int e = 0; e < 3; e++) begin
      b   = (e == 2) ? 0 : e + 1;
      opp = (sign_i[e].neg & !sign_i[b].neg & !sign_i[b].zero) |
            (sign_i[b].neg & !sign_i[e].neg & !sign_i[e].zero);
      if (np != 2'd2) begin
        if (sign_i[e].zero) begin
          // A vertex already taken at the same coordinates is not taken twice.
          dup = (np == 2'd1) && (pts[0][0] == v_i[e][0]) &&
                (pts[0][1] == v_i[e][1]) && (pts[0][2] == v_i[e][2]);
          if (!dup) begin
            for (int i = 0; i < 3; i++) pts[np[0]][i] = v_i[e][i];
            np = np + 2'd1;
          end
        end else if (opp) begin
          for (int i = 0; i < 3; i++) pts[np[0]][i] = pt_i[e][i];
          np = np + 2'd1;
        end
      end
    end
    if (bypass_i)                  verdict = tps_pkg::VERDICT_BYPASS;
    else if (all_pos)              verdict = tps_pkg::VERDICT_REMOVED;
    else if (all_neg || all_zero)  verdict = tps_pkg::VERDICT_KEPT;
    else if (np == 2'd2)           verdict = tps_pkg::VERDICT_CUT;
    else                           verdict = tps_pkg::VERDICT_KEPT;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= 1'b0;
      removed_q <= '0;
      kept_q    <= '0;
      cut_q     <= '0;
    end else if (en_i) begin
      valid_q <= valid_i;
      if (valid_i) begin
        case (verdict)
          tps_pkg::VERDICT_REMOVED: if (removed_q != '1) removed_q <= removed_q + 1'b1;
          tps_pkg::VERDICT_KEPT:    if (kept_q != '1) kept_q <= kept_q + 1'b1;
          tps_pkg::VERDICT_CUT:     if (cut_q != '1) cut_q <= cut_q + 1'b1;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && valid_i) begin
      verdict_q <= verdict;
      for (int j = 0; j < 2; j++)
        for (int i = 0; i < 3; i++)
          p_q[j][i] <= (verdict == tps_pkg::VERDICT_CUT) ? pts[j][i] : '0;
    end
  end

  assign valid_o   = valid_q;
  assign verdict_o = verdict_q;
  assign p_o       = p_q;
  assign removed_o = removed_q;
  assign kept_o    = kept_q;
  assign cut_o     = cut_q;

endmodule

[design/triangle_plane_section.sv]
// Triangle plane section, top level: configuration registers, vertex and
// edge lanes, alignment line and merging stage. Depends on tps_pkg and
// tps_dist, tps_edge, tps_merge.
//
// Input channel: one triangle word (nine signed coordinates) is taken at a
// rising edge with in_valid_i high and in_stall_o low. Output channel: one
// result word (verdict, two segment points, three running counts) leaves at
// an edge with out_valid_o high and out_stall_i low.
// The pipeline has two stages for the distances, one for the edge set-up,
// COORD_BITS + 1 stages of the interpolating divider (one quotient bit each)
// and the merging stage. Throughput is one triangle per cycle while no
// result is stalled; the divider in each edge lane is a full pipeline.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and in_stall_o is raised in the same cycle.
// Reset clears the pipeline valid bits and the counts and loads the register
// defaults: plane disabled, normal along +z, zero offset. The APB port is
// always ready; registers sit at byte addresses 0, 4, 8, 12 and 16.
module triangle_plane_section #(
  parameter int COORD_BITS = 32,
  parameter int COUNT_BITS = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic signed [COORD_BITS-1:0] ax_i,
  input  logic signed [COORD_BITS-1:0] ay_i,
  input  logic signed [COORD_BITS-1:0] az_i,
  input  logic signed [COORD_BITS-1:0] bx_i,
  input  logic signed [COORD_BITS-1:0] by_coord_i,
  input  logic signed [COORD_BITS-1:0] bz_i,
  input  logic signed [COORD_BITS-1:0] cx_i,
  input  logic signed [COORD_BITS-1:0] cy_i,
  input  logic signed [COORD_BITS-1:0] cz_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [1:0]                   verdict_o,
  output logic signed [COORD_BITS-1:0] p0x_o,
  output logic signed [COORD_BITS-1:0] p0y_o,
  output logic signed [COORD_BITS-1:0] p0z_o,
  output logic signed [COORD_BITS-1:0] p1x_o,
  output logic signed [COORD_BITS-1:0] p1y_o,
  output logic signed [COORD_BITS-1:0] p1z_o,
  output logic [COUNT_BITS-1:0]        removed_total_o,
  output logic [COUNT_BITS-1:0]        kept_total_o,
  output logic [COUNT_BITS-1:0]        cut_total_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [4:0]                   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  localparam int CB    = COORD_BITS;
  localparam int DW    = ((CB + 20 > 48) ? CB + 20 : 48) + 1;
  localparam int LINE  = CB + 2;
  localparam int NBITS = tps_pkg::NORMAL_BITS;

  // Configuration registers.
  logic                               enable_q;
  logic signed [NBITS-1:0]            nx_q, ny_q, nz_q;
  logic signed [tps_pkg::OFFSET_BITS-1:0] offset_q;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= 1'b0;
      nx_q     <= '0;
      ny_q     <= '0;
      nz_q     <= NBITS'(65536);
      offset_q <= '0;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[4:2])
        tps_pkg::REG_ENABLE: enable_q <= pwdata[0];
        tps_pkg::REG_NX:     nx_q     <= pwdata[NBITS-1:0];
        tps_pkg::REG_NY:     ny_q     <= pwdata[NBITS-1:0];
        tps_pkg::REG_NZ:     nz_q     <= pwdata[NBITS-1:0];
        tps_pkg::REG_OFFSET: offset_q <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      tps_pkg::REG_ENABLE: prdata = {31'd0, enable_q};
      tps_pkg::REG_NX:     prdata = {{(32-NBITS){1'b0}}, nx_q};
      tps_pkg::REG_NY:     prdata = {{(32-NBITS){1'b0}}, ny_q};
      tps_pkg::REG_NZ:     prdata = {{(32-NBITS){1'b0}}, nz_q};
      tps_pkg::REG_OFFSET: prdata = offset_q;
      default:             prdata = '0;
    endcase
  end

  logic bypass;
  assign bypass = !enable_q || (nx_q == '0 && ny_q == '0 && nz_q == '0);

  // Global hold: the whole pipeline advances unless a result is waiting and stalled.
  logic en;
  assign in_stall_o = out_valid_o && out_stall_i;
  assign en         = !in_stall_o;

  logic signed [CB-1:0] vin [3][3];
  assign vin[0][0] = ax_i;  assign vin[0][1] = ay_i;        assign vin[0][2] = az_i;
  assign vin[1][0] = bx_i;  assign vin[1][1] = by_coord_i;  assign vin[1][2] = bz_i;
  assign vin[2][0] = cx_i;  assign vin[2][1] = cy_i;        assign vin[2][2] = cz_i;

  logic                 v1_q, v2_q;
  logic signed [CB-1:0] vs1_q [3][3];
  logic signed [CB-1:0] vs2_q [3][3];
  logic                 lv_q   [LINE];
  logic signed [CB-1:0] lvert_q [LINE][3][3];
  tps_pkg::dsign_t      lsign_q [LINE][3];

  logic signed [DW-1:0] d    [3];
  tps_pkg::dsign_t      sgn  [3];
  logic signed [CB-1:0] pt   [3][3];

  for (genvar c = 0; c < 3; c++) begin : g_vertex
    tps_dist #(.CB(CB), .DW(DW)) u_dist (
      .clk_i    (clk_i),
      .en_i     (en),
      .x_i      (vin[c][0]),
      .y_i      (vin[c][1]),
      .z_i      (vin[c][2]),
      .nx_i     (nx_q),
      .ny_i     (ny_q),
      .nz_i     (nz_q),
      .offset_i (offset_q),
      .d_o      (d[c]),
      .sign_o   (sgn[c])
    );
  end

  for (genvar e = 0; e < 3; e++) begin : g_edge
    localparam int B = (e == 2) ? 0 : e + 1;
    tps_edge #(.CB(CB), .DW(DW)) u_edge (
      .clk_i (clk_i),
      .en_i  (en),
      .da_i  (d[e]),
      .db_i  (d[B]),
      .va_i  (vs2_q[e]),
      .vb_i  (vs2_q[B]),
      .pt_o  (pt[e])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      for (int s = 0; s < LINE; s++) lv_q[s] <= 1'b0;
    end else if (en) begin
      v1_q    <= in_valid_i;
      v2_q    <= v1_q;
      lv_q[0] <= v2_q;
      for (int s = 1; s < LINE; s++) lv_q[s] <= lv_q[s-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      vs1_q      <= vin;
      vs2_q      <= vs1_q;
      lvert_q[0] <= vs2_q;
      lsign_q[0] <= sgn;
      for (int s = 1; s < LINE; s++) begin
        lvert_q[s] <= lvert_q[s-1];
        lsign_q[s] <= lsign_q[s-1];
      end
    end
  end

  logic signed [CB-1:0] p [2][3];

  tps_merge #(.CB(CB), .NB(COUNT_BITS)) u_merge (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .valid_i   (lv_q[LINE-1]),
    .bypass_i  (bypass),
    .sign_i    (lsign_q[LINE-1]),
    .v_i       (lvert_q[LINE-1]),
    .pt_i      (pt),
    .valid_o   (out_valid_o),
    .verdict_o (verdict_o),
    .p_o       (p),
    .removed_o (removed_total_o),
    .kept_o    (kept_total_o),
    .cut_o     (cut_total_o)
  );

  assign p0x_o = p[0][0];
  assign p0y_o = p[0][1];
  assign p0z_o = p[0][2];
  assign p1x_o = p[1][0];
  assign p1y_o = p[1][1];
  assign p1z_o = p[1][2];

`ifndef NO_ASSERTIONS
  a_points_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && verdict_o != tps_pkg::VERDICT_CUT |->
      p0x_o == '0 && p0y_o == '0 && p0z_o == '0 &&
      p1x_o == '0 && p1y_o == '0 && p1z_o == '0)
    else $error("segment points not zero for a triangle that is not cut");
  a_hold_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      $stable(removed_total_o) && $stable(kept_total_o) && $stable(cut_total_o))
    else $error("counts changed while the result was stalled");
  a_one_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> (removed_total_o - $past(removed_total_o)) +
             (kept_total_o - $past(kept_total_o)) +
             (cut_total_o - $past(cut_total_o)) <= COUNT_BITS'(1))
    else $error("counts moved by more than one triangle in a cycle");
  a_bypass_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && verdict_o == tps_pkg::VERDICT_BYPASS &&
      !lv_q[LINE-1] |=>
      $stable(removed_total_o) && $stable(kept_total_o) && $stable(cut_total_o))
    else $error("counts changed with no triangle in the merging stage");
`endif

endmodule
